### rtl/ssc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ssc_pkg;

  localparam int SQ_IN_W  = 68;
  localparam int SQ_OUT_W = SQ_IN_W / 2;
  localparam int SQ_REM_W = SQ_OUT_W + 3;
  localparam int SQ_LAT   = SQ_OUT_W;
  localparam int Q_W      = 31;
  localparam int DIV_LAT  = Q_W;
  localparam int RB_W     = 46;
  localparam int RS_W     = RB_W + 1;

  typedef struct packed {
    logic                  valid;
    logic                  hit;
    logic [31:0]           ch;
    logic [2:0]            neg;
    logic [2:0][31:0]      mag;
    logic [2:0][31:0]      ac;
    logic [2:0][31:0]      bc;
    logic [RS_W-1:0]       rs;
    logic [RB_W-1:0]       rb;
    logic [SQ_OUT_W-1:0]   distance;
  } side_t;

endpackage
`default_nettype wire

### rtl/ssc_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module ssc_sqrt
  import ssc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic [SQ_IN_W-1:0]  rad,
  output logic      [SQ_OUT_W-1:0] root
);

  logic [SQ_IN_W-1:0]  rad_q  [0:SQ_LAT];
  logic [SQ_REM_W-1:0] rem_q  [0:SQ_LAT];
  logic [SQ_OUT_W-1:0] root_q [0:SQ_LAT];

  assign rad_q[0]  = rad;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;

  for (genvar i = 0; i < SQ_LAT; i++) begin : g_stage
    logic [SQ_REM_W-1:0] cur;
    logic [SQ_REM_W-1:0] trial;
    assign cur   = {rem_q[i][SQ_REM_W-3:0], rad_q[i][SQ_IN_W-1-2*i -: 2]};
    assign trial = {1'b0, root_q[i], 2'b01};
    always_ff @(posedge clk) begin
      rad_q[i+1] <= rad_q[i];
      if (cur >= trial) begin
        rem_q[i+1]  <= cur - trial;
        root_q[i+1] <= {root_q[i][SQ_OUT_W-2:0], 1'b1};
      end else begin
        rem_q[i+1]  <= cur;
        root_q[i+1] <= {root_q[i][SQ_OUT_W-2:0], 1'b0};
      end
    end
  end

  assign root = root_q[SQ_LAT];

endmodule
`default_nettype wire

### rtl/ssc_div.sv
`timescale 1ns / 1ps
`default_nettype none
module ssc_div
  import ssc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic [31:0]         mag,
  input  wire logic [SQ_OUT_W-1:0] divisor,
  output logic      [Q_W-1:0]      quo
);

  logic [SQ_OUT_W-1:0] rem_q [0:DIV_LAT];
  logic [SQ_OUT_W-1:0] den_q [0:DIV_LAT];
  logic [Q_W-1:0]      quo_q [0:DIV_LAT];

  assign rem_q[0] = {3'b000, mag[31:1]};
  assign den_q[0] = divisor;
  assign quo_q[0] = '0;

  for (genvar j = 0; j < DIV_LAT; j++) begin : g_stage
    logic [SQ_OUT_W:0] cur;
    logic              dbit;
    assign dbit = (j == 0) ? mag[0] : 1'b0;
    assign cur  = {rem_q[j], dbit};
    always_ff @(posedge clk) begin
      den_q[j+1] <= den_q[j];
      if (cur >= {1'b0, den_q[j]}) begin
        rem_q[j+1] <= SQ_OUT_W'(cur - {1'b0, den_q[j]});
        quo_q[j+1] <= {quo_q[j][Q_W-2:0], 1'b1};
      end else begin
        rem_q[j+1] <= cur[SQ_OUT_W-1:0];
        quo_q[j+1] <= {quo_q[j][Q_W-2:0], 1'b0};
      end
    end
  end

  assign quo = quo_q[DIV_LAT];

endmodule
`default_nettype wire

### rtl/sphere_sphere_collision_core.sv
// sphere pair intersection test, one pair per transaction
// a transaction is taken at a rising edge with start high and busy low;
// busy is always low, so a new pair can be given in every cycle
// inputs: channel masks, Q16.16 centers, radii and largest scale axes
// of spheres a and b
// each result shows on the result ports for one cycle with done high
// throughput is one pair per cycle; the pipeline includes the 34-stage
// square root pipeline and the 31-stage normal divider pipelines
// a result is hit, penetration depth, distance, Q1.30 normal from b to a,
// contact point on b and the shared channels; a miss gives all zeros
// results leave in the order the pairs came in
// reset clears all valid bits so no result appears until a new pair
// the receiver cannot stall, so no backpressure is needed
`timescale 1ns / 1ps
`default_nettype none
module sphere_sphere_collision_core
  import ssc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic        [31:0] a_channel_mask,
  input  wire logic        [31:0] b_channel_mask,
  input  wire logic signed [31:0] a_center_x,
  input  wire logic signed [31:0] a_center_y,
  input  wire logic signed [31:0] a_center_z,
  input  wire logic        [30:0] a_radius,
  input  wire logic        [30:0] a_scale_max,
  input  wire logic signed [31:0] b_center_x,
  input  wire logic signed [31:0] b_center_y,
  input  wire logic signed [31:0] b_center_z,
  input  wire logic        [30:0] b_radius,
  input  wire logic        [30:0] b_scale_max,
  output logic                    done,
  output logic                    hit,
  output logic             [31:0] penetration_depth,
  output logic             [31:0] hit_distance,
  output logic signed      [31:0] normal_x,
  output logic signed      [31:0] normal_y,
  output logic signed      [31:0] normal_z,
  output logic signed      [31:0] hit_point_x,
  output logic signed      [31:0] hit_point_y,
  output logic signed      [31:0] hit_point_z,
  output logic             [31:0] hit_channels
);

  assign busy = 1'b0;

  // stage 1: capture
  logic             v1;
  logic [31:0]      ma1, mb1;
  logic [2:0][31:0] ac1, bc1;
  logic [30:0]      ar1, as1, br1, bs1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start & ~busy;
    ma1 <= a_channel_mask;
    mb1 <= b_channel_mask;
    ac1 <= {a_center_z, a_center_y, a_center_x};
    bc1 <= {b_center_z, b_center_y, b_center_x};
    ar1 <= a_radius;
    as1 <= a_scale_max;
    br1 <= b_radius;
    bs1 <= b_scale_max;
  end

  // stage 2: differences and radius products
  logic             v2;
  logic [31:0]      ch2;
  logic [2:0]       neg2;
  logic [2:0][31:0] mag2, ac2, bc2;
  logic [61:0]      pa2, pb2;
  logic [2:0][32:0] df1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      df1[i] = {ac1[i][31], ac1[i]} - {bc1[i][31], bc1[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    ch2 <= ma1 & mb1;
    ac2 <= ac1;
    bc2 <= bc1;
    pa2 <= 62'(ar1) * 62'(as1);
    pb2 <= 62'(br1) * 62'(bs1);
    for (int i = 0; i < 3; i++) begin
      neg2[i] <= df1[i][32];
      mag2[i] <= df1[i][32] ? 32'(-df1[i]) : df1[i][31:0];
    end
  end

  // stage 3: squares and radius sum
  logic             v3;
  logic [31:0]      ch3;
  logic [2:0]       neg3;
  logic [2:0][31:0] mag3, ac3, bc3;
  logic [2:0][63:0] sq3;
  logic [RS_W-1:0]  rs3;
  logic [RB_W-1:0]  rb3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    ch3  <= ch2;
    neg3 <= neg2;
    mag3 <= mag2;
    ac3  <= ac2;
    bc3  <= bc2;
    rb3  <= pb2[61:16];
    rs3  <= RS_W'(pa2[61:16]) + RS_W'(pb2[61:16]);
    for (int i = 0; i < 3; i++) begin
      sq3[i] <= 64'(mag2[i]) * 64'(mag2[i]);
    end
  end

  // stage 4: sum of squares
  side_t            side4;
  logic [65:0]      sum4;

  always_ff @(posedge clk) begin
    if (rst) side4.valid <= 1'b0;
    else     side4.valid <= v3;
    side4.hit      <= 1'b0;
    side4.ch       <= ch3;
    side4.neg      <= neg3;
    side4.mag      <= mag3;
    side4.ac       <= ac3;
    side4.bc       <= bc3;
    side4.rs       <= rs3;
    side4.rb       <= rb3;
    side4.distance <= '0;
    sum4 <= 66'(sq3[0]) + 66'(sq3[1]) + 66'(sq3[2]);
  end

  logic [SQ_OUT_W-1:0] root;

  ssc_sqrt u_sqrt (
    .clk  (clk),
    .rad  ({{(SQ_IN_W-66){1'b0}}, sum4}),
    .root (root)
  );

  side_t line_a [0:SQ_LAT-1];

  always_ff @(posedge clk) begin
    for (int k = 0; k < SQ_LAT; k++) begin
      if (rst)         line_a[k] <= '0;
      else if (k == 0) line_a[k] <= side4;
      else             line_a[k] <= line_a[k-1];
    end
  end

  // stage 5: hit decision
  side_t side5, side5_next;

  always_comb begin
    side5_next          = line_a[SQ_LAT-1];
    side5_next.distance = root;
    side5_next.hit      = (line_a[SQ_LAT-1].ch != '0) &&
                          ({{(RS_W-SQ_OUT_W){1'b0}}, root} <= line_a[SQ_LAT-1].rs);
  end

  always_ff @(posedge clk) begin
    if (rst) side5 <= '0;
    else     side5 <= side5_next;
  end

  logic [2:0][Q_W-1:0] quo;

  for (genvar i = 0; i < 3; i++) begin : g_div
    ssc_div u_div (
      .clk     (clk),
      .mag     (side5.mag[i]),
      .divisor (side5.distance),
      .quo     (quo[i])
    );
  end

  side_t line_b [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_LAT; k++) begin
      if (rst)         line_b[k] <= '0;
      else if (k == 0) line_b[k] <= side5;
      else             line_b[k] <= line_b[k-1];
    end
  end

  // stage 6: clamp and partial products of q * rb
  side_t               side6;
  logic [2:0][Q_W-1:0] q6;
  logic [2:0][53:0]    plo6, phi6;
  logic [2:0][Q_W-1:0] qc5;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc5[i] = (quo[i] > Q_W'(31'h4000_0000)) ? Q_W'(31'h4000_0000) : quo[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) side6 <= '0;
    else     side6 <= line_b[DIV_LAT-1];
    q6 <= qc5;
    for (int i = 0; i < 3; i++) begin
      plo6[i] <= 54'(qc5[i]) * 54'(line_b[DIV_LAT-1].rb[22:0]);
      phi6[i] <= 54'(qc5[i]) * 54'(line_b[DIV_LAT-1].rb[45:23]);
    end
  end

  // stage 7: contact offset
  side_t               side7;
  logic [2:0][Q_W-1:0] q7;
  logic [2:0][46:0]    off7;
  logic [2:0][76:0]    full6;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      full6[i] = {phi6[i], 23'b0} + 77'(plo6[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) side7 <= '0;
    else     side7 <= side6;
    q7 <= q6;
    for (int i = 0; i < 3; i++) begin
      off7[i] <= full6[i][76:30];
    end
  end

  // stage 8: result
  logic [2:0][31:0] nrm7, hp7;
  logic [2:0][48:0] sum7;
  logic [RS_W-1:0]  dep7;

  always_comb begin
    dep7 = side7.rs - {{(RS_W-SQ_OUT_W){1'b0}}, side7.distance};
    for (int i = 0; i < 3; i++) begin
      if (side7.neg[i]) begin
        nrm7[i] = 32'(-{1'b0, q7[i]});
        sum7[i] = {{17{side7.bc[i][31]}}, side7.bc[i]} - {2'b00, off7[i]};
      end else begin
        nrm7[i] = {1'b0, q7[i]};
        sum7[i] = {{17{side7.bc[i][31]}}, side7.bc[i]} + {2'b00, off7[i]};
      end
      if (!sum7[i][48] && (sum7[i][47:31] != '0))     hp7[i] = 32'h7FFF_FFFF;
      else if (sum7[i][48] && (sum7[i][47:31] != '1)) hp7[i] = 32'h8000_0000;
      else                                            hp7[i] = sum7[i][31:0];
    end
    if (side7.distance == '0) begin
      nrm7 = {32'd0, 32'h4000_0000, 32'd0};
      hp7  = side7.ac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= side7.valid;
    hit <= side7.hit;
    if (side7.hit) begin
      penetration_depth <= (dep7[RS_W-1:32] != '0) ? 32'hFFFF_FFFF : dep7[31:0];
      hit_distance <= (side7.distance[SQ_OUT_W-1:32] != '0) ? 32'hFFFF_FFFF
                                                            : side7.distance[31:0];
      normal_x     <= nrm7[0];
      normal_y     <= nrm7[1];
      normal_z     <= nrm7[2];
      hit_point_x  <= hp7[0];
      hit_point_y  <= hp7[1];
      hit_point_z  <= hp7[2];
      hit_channels <= side7.ch;
    end else begin
      penetration_depth <= '0;
      hit_distance      <= '0;
      normal_x          <= '0;
      normal_y          <= '0;
      normal_z          <= '0;
      hit_point_x       <= '0;
      hit_point_y       <= '0;
      hit_point_z       <= '0;
      hit_channels      <= '0;
    end
  end

endmodule
`default_nettype wire
